@@ sv/lcdsr_pkg.sv @@
// Shared types and constants for the character LCD shift register driver.
// No dependencies; imported by every module of the block.
package lcdsr_pkg;

    localparam int FRAME_W = 8;
    localparam int WAIT_W  = 12;
    localparam int UNIT_W  = 8;

    localparam logic [2:0] OP_CMD   = 3'd0;
    localparam logic [2:0] OP_DATA  = 3'd1;
    localparam logic [2:0] OP_INIT  = 3'd2;
    localparam logic [2:0] OP_GOTO  = 3'd3;
    localparam logic [2:0] OP_CLRHM = 3'd4;

    localparam logic [7:0] MASK_RS_CLR = 8'hFB;
    localparam logic [7:0] RS_BIT      = 8'h04;
    localparam logic [7:0] MASK_E_CLR  = 8'hF7;
    localparam logic [7:0] E_BIT       = 8'h08;
    localparam logic [7:0] MASK_HI     = 8'hF0;
    localparam logic [7:0] MASK_LO     = 8'h0F;

    typedef enum logic [2:0] {
        SK_RS_CLR,
        SK_RS_SET,
        SK_LOAD,
        SK_LOAD_LONG,
        SK_NIB,
        SK_E_HI,
        SK_E_LO
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRE,
        ST_INIB,
        ST_BYTE
    } t_state;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] operand;
        logic       last;
    } t_step;

endpackage

@@ sv/lcdsr_frame_unit.sv @@
// Shared frame unit: applies one step to the shadow byte and scales the delay.
// Depends on lcdsr_pkg.
module lcdsr_frame_unit (
    input  lcdsr_pkg::t_step                  i_step,
    input  logic [lcdsr_pkg::FRAME_W-1:0]     i_shadow,
    input  logic [lcdsr_pkg::UNIT_W-1:0]      i_wait_unit,
    output logic [lcdsr_pkg::FRAME_W-1:0]     o_shadow,
    output logic [lcdsr_pkg::WAIT_W-1:0]      o_wait_ms
);
    import lcdsr_pkg::*;

    logic [WAIT_W-1:0] unit_x1;
    logic [WAIT_W-1:0] unit_x10;

    assign unit_x1  = {{(WAIT_W-UNIT_W){1'b0}}, i_wait_unit};
    assign unit_x10 = (unit_x1 << 3) + (unit_x1 << 1);

    always_comb begin
        o_shadow  = i_shadow;
        o_wait_ms = '0;
        case (i_step.kind)
            SK_RS_CLR:    o_shadow = i_shadow & MASK_RS_CLR;
            SK_RS_SET:    o_shadow = i_shadow | RS_BIT;
            SK_LOAD:      o_shadow = i_step.operand;
            SK_LOAD_LONG: begin
                o_shadow  = i_step.operand;
                o_wait_ms = unit_x10;
            end
            SK_NIB:       o_shadow = (i_shadow & MASK_LO) | (i_step.operand & MASK_HI);
            SK_E_HI: begin
                o_shadow  = i_shadow | E_BIT;
                o_wait_ms = unit_x1;
            end
            SK_E_LO: begin
                o_shadow  = i_shadow & MASK_E_CLR;
                o_wait_ms = unit_x1;
            end
            default: begin
                o_shadow  = i_shadow;
                o_wait_ms = '0;
            end
        endcase
    end

endmodule

@@ sv/lcdsr_seq.sv @@
// Step sequencer: walks the frame script of one operation, one step per advance.
// Depends on lcdsr_pkg.
module lcdsr_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [2:0]       i_opcode,
    input  logic [7:0]       i_value,
    input  logic [5:0]       i_column,
    input  logic             i_row,
    input  logic             i_adv,
    output logic             o_busy,
    output lcdsr_pkg::t_step o_step
);
    import lcdsr_pkg::*;

    t_state     r_state, n_state;
    logic [2:0] r_sub, n_sub;
    logic [1:0] r_idx, n_idx;
    logic [2:0] r_op;
    logic [7:0] r_value;
    logic [5:0] r_col;
    logic       r_row;

    logic [7:0] cur_byte;
    logic [1:0] last_idx;
    logic [7:0] init_nib;

    always_comb begin
        cur_byte = r_value;
        last_idx = 2'd0;
        case (r_op)
            OP_CMD, OP_DATA: cur_byte = r_value;
            OP_GOTO:         cur_byte = {1'b1, r_row, r_col};
            OP_CLRHM: begin
                last_idx = 2'd1;
                cur_byte = (r_idx == 2'd0) ? 8'h01 : 8'h02;
            end
            OP_INIT: begin
                last_idx = 2'd3;
                case (r_idx)
                    2'd0:    cur_byte = 8'h28;
                    2'd1:    cur_byte = 8'h0C;
                    2'd2:    cur_byte = 8'h01;
                    default: cur_byte = 8'h06;
                endcase
            end
            default: cur_byte = r_value;
        endcase
        init_nib = (r_idx == 2'd3) ? 8'h20 : 8'h30;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sub   <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_sub   <= n_sub;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_start) begin
            r_op    <= i_opcode;
            r_value <= i_value;
            r_col   <= i_column;
            r_row   <= i_row;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_sub          = r_sub;
        n_idx          = r_idx;
        o_busy         = 1'b1;
        o_step.kind    = SK_E_LO;
        o_step.operand = cur_byte;
        o_step.last    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                n_sub  = '0;
                n_idx  = '0;
                if (i_start) begin
                    case (i_opcode)
                        OP_INIT:                           n_state = ST_PRE;
                        OP_CMD, OP_DATA, OP_GOTO, OP_CLRHM: n_state = ST_BYTE;
                        default:                           n_state = ST_IDLE;
                    endcase
                end
            end
            ST_PRE: begin
                o_step.kind    = SK_LOAD_LONG;
                o_step.operand = E_BIT;
                if (i_adv) begin
                    n_state = ST_INIB;
                end
            end
            ST_INIB: begin
                o_step.operand = init_nib;
                case (r_sub)
                    3'd0:    o_step.kind = SK_LOAD;
                    3'd1:    o_step.kind = SK_E_HI;
                    default: o_step.kind = SK_E_LO;
                endcase
                if (i_adv) begin
                    if (r_sub == 3'd2) begin
                        n_sub = '0;
                        if (r_idx == 2'd3) begin
                            n_idx   = '0;
                            n_state = ST_BYTE;
                        end else begin
                            n_idx = r_idx + 2'd1;
                        end
                    end else begin
                        n_sub = r_sub + 3'd1;
                    end
                end
            end
            ST_BYTE: begin
                case (r_sub)
                    3'd0:       o_step.kind = (r_op == OP_DATA) ? SK_RS_SET : SK_RS_CLR;
                    3'd1:       o_step.kind = SK_NIB;
                    3'd4: begin
                        o_step.kind    = SK_NIB;
                        o_step.operand = {cur_byte[3:0], 4'b0000};
                    end
                    3'd2, 3'd5: o_step.kind = SK_E_HI;
                    default:    o_step.kind = SK_E_LO;
                endcase
                o_step.last = (r_sub == 3'd6) && (r_idx == last_idx);
                if (i_adv) begin
                    if (r_sub == 3'd6) begin
                        n_sub = '0;
                        if (r_idx == last_idx) begin
                            n_idx   = '0;
                            n_state = ST_IDLE;
                        end else begin
                            n_idx = r_idx + 2'd1;
                        end
                    end else begin
                        n_sub = r_sub + 3'd1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
                o_busy  = 1'b0;
            end
        endcase
    end

endmodule

@@ sv/char_lcd_shift_register_driver_core.sv @@
// Top level of the character LCD shift register driver.
// Depends on lcdsr_pkg, lcdsr_seq and lcdsr_frame_unit.
//
// Each accepted beat requests one LCD operation and yields a run of frames,
// the byte to latch into the shift register plus the delay in ms after it,
// with tlast on the final frame. The step sequencer feeds one shared frame
// unit, which produces one frame per cycle while the output side accepts:
// command, data and goto yield 7 frames, clear-and-home 14 and init 41;
// an undefined opcode is consumed with no output. o_s_tready stays low
// while a run is generated.
// wait_unit_ms resets to 2 and is written through i_cfg_we / i_cfg_wdata.
module char_lcd_shift_register_driver_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // opcode[2:0], value[10:3], column[16:11], row[17], zero
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // frame[7:0], wait_ms[19:8], zero
    output logic        o_m_tlast
);
    import lcdsr_pkg::*;

    logic [UNIT_W-1:0]  r_wait_unit;
    logic [FRAME_W-1:0] r_shadow;
    logic               r_out_valid;
    logic [FRAME_W-1:0] r_frame;
    logic [WAIT_W-1:0]  r_wait;
    logic               r_last;

    logic               busy;
    logic               start;
    logic               adv;
    t_step              step;
    logic [FRAME_W-1:0] fu_shadow;
    logic [WAIT_W-1:0]  fu_wait;

    assign o_s_tready = !busy;
    assign start      = i_s_tvalid && !busy;
    assign adv        = busy && (!r_out_valid || i_m_tready);

    lcdsr_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_s_tdata[2:0]),
        .i_value  (i_s_tdata[10:3]),
        .i_column (i_s_tdata[16:11]),
        .i_row    (i_s_tdata[17]),
        .i_adv    (adv),
        .o_busy   (busy),
        .o_step   (step)
    );

    lcdsr_frame_unit u_fu (
        .i_step      (step),
        .i_shadow    (r_shadow),
        .i_wait_unit (r_wait_unit),
        .o_shadow    (fu_shadow),
        .o_wait_ms   (fu_wait)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait_unit <= 8'd2;
        end else if (i_cfg_we) begin
            r_wait_unit <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shadow    <= '0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_shadow    <= fu_shadow;
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_frame <= fu_shadow;
            r_wait  <= fu_wait;
            r_last  <= step.last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_wait, r_frame};
    assign o_m_tlast  = r_last;

endmodule
